### rtl/tkrc_pkg.sv
// Shared constants and types for the keyed route cache.
package tkrc_pkg;

  localparam int unsigned ENTRIES   = 32;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned ROUTE_W   = 64;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned TTL_W     = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned RES_IDX_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_W      = 184;
  localparam int unsigned OUT_W     = 72;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
  localparam logic [OP_W-1:0] OP_FOUND   = 2'd1;
  localparam logic [OP_W-1:0] OP_MISSING = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FOUND_TTL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING_TTL = 1'b1;

  localparam logic [TTL_W-1:0] FOUND_TTL_RST   = 32'd3600000;
  localparam logic [TTL_W-1:0] MISSING_TTL_RST = 32'd900000;

  // Key and time seen by every cell during a scan
  typedef struct packed {
    logic              key_nz;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } probe_t;

  // Running search result handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               match;
    logic [IDX_W-1:0]   match_idx;
    logic [TIME_W-1:0]  match_exp;
    logic [ROUTE_W-1:0] match_route;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
    logic               best_have;
    logic [TIME_W-1:0]  best_exp;
    logic [IDX_W-1:0]   best_idx;
  } scan_t;

  // Entry update broadcast to the row
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [ROUTE_W-1:0] route;
    logic [TIME_W-1:0]  exp;
  } wr_t;

endpackage

### rtl/tkrc_cell.sv
// One table entry plus its stage of the search chain.
module tkrc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tkrc_pkg::IDX_W-1:0]  cell_idx_i,
  input  tkrc_pkg::probe_t            probe_i,
  input  tkrc_pkg::wr_t               wr_i,
  input  tkrc_pkg::scan_t             scan_i,
  output tkrc_pkg::scan_t             scan_o
);
  import tkrc_pkg::*;

  logic [KEY_W-1:0]   key_q;
  logic [ROUTE_W-1:0] route_q;
  logic [TIME_W-1:0]  exp_q;
  scan_t              scan_d, scan_q;
  logic               hit, avail;

  assign hit   = probe_i.key_nz && (key_q == probe_i.key);
  assign avail = (key_q == '0) || (probe_i.now >= exp_q);

  always_comb begin
    scan_d = scan_i;
    if (!scan_i.match && hit) begin
      scan_d.match       = 1'b1;
      scan_d.match_idx   = cell_idx_i;
      scan_d.match_exp   = exp_q;
      scan_d.match_route = route_q;
    end
    if (!scan_i.free && avail) begin
      scan_d.free     = 1'b1;
      scan_d.free_idx = cell_idx_i;
    end
    // strict compare keeps the lowest index on ties
    if (!scan_i.best_have || (exp_q < scan_i.best_exp)) begin
      scan_d.best_have = 1'b1;
      scan_d.best_exp  = exp_q;
      scan_d.best_idx  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      route_q <= '0;
      exp_q   <= '0;
      scan_q  <= '0;
    end else begin
      scan_q <= scan_d;
      if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
        key_q   <= wr_i.key;
        route_q <= wr_i.route;
        exp_q   <= wr_i.exp;
      end
    end
  end

  assign scan_o = scan_q;

endmodule

### rtl/tkrc_ctrl.sv
// Request sequencing, TTL registers, result decode and output register.
module tkrc_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tkrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tkrc_pkg::TTL_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tkrc_pkg::OP_W-1:0]           opcode_i,
  input  logic [tkrc_pkg::KEY_W-1:0]          callsign_key_i,
  input  logic [tkrc_pkg::ROUTE_W-1:0]        route_in_i,
  input  logic [tkrc_pkg::TIME_W-1:0]         now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                route_hit_o,
  output logic [tkrc_pkg::ROUTE_W-1:0]        route_out_o,
  output logic                                lookup_due_o,
  output logic                                entry_written_o,
  output logic [tkrc_pkg::RES_IDX_W-1:0]      entry_index_o,
  output tkrc_pkg::probe_t                    probe_o,
  output tkrc_pkg::scan_t                     head_o,
  input  tkrc_pkg::scan_t                     tail_i,
  output tkrc_pkg::wr_t                       wr_o
);
  import tkrc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [TTL_W-1:0]   found_ttl_q, missing_ttl_q;
  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   key_q;
  logic [ROUTE_W-1:0] route_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  exp_q;
  logic               start_q;
  scan_t              res_q;
  wr_t                wr_q;
  logic               out_valid_q;
  logic               hit_q, due_q, written_q;
  logic [ROUTE_W-1:0] rout_q;
  logic [RES_IDX_W-1:0] oidx_q;

  logic                in_acc, out_free, finish;
  logic [TTL_W-1:0]    ttl_sel;
  logic [TIME_W:0]     exp_sum;
  logic [TIME_W-1:0]   exp_d;
  logic                hit_d, due_d, wr_d;
  logic [ROUTE_W-1:0]  rout_d;
  logic [IDX_W-1:0]    idx_d;
  logic [IDX_W+RES_IDX_W-1:0] idx_wide;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign finish      = (state_q == ST_DONE) && out_free;

  // expiry for a mark, saturated at the top of the time range
  assign ttl_sel = (opcode_i == OP_FOUND) ? found_ttl_q : missing_ttl_q;
  assign exp_sum = (TIME_W+1)'(now_ms_i) + (TIME_W+1)'(ttl_sel);
  assign exp_d   = exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];

  assign probe_o = '{key_nz: (key_q != '0), key: key_q, now: now_q};

  always_comb begin
    head_o           = '0;
    head_o.valid     = start_q;
  end

  always_comb begin
    hit_d  = 1'b0;
    due_d  = 1'b0;
    wr_d   = 1'b0;
    rout_d = '0;
    idx_d  = '0;
    case (op_q)
      OP_QUERY: begin
        if (key_q != '0) begin
          if (res_q.match) begin
            idx_d = res_q.match_idx;
            if (now_q >= res_q.match_exp) begin
              due_d = 1'b1;
            end else if (res_q.match_route != '0) begin
              hit_d  = 1'b1;
              rout_d = res_q.match_route;
            end
          end else begin
            due_d = 1'b1;
          end
        end
      end
      OP_FOUND, OP_MISSING: begin
        if (key_q != '0) begin
          wr_d = 1'b1;
          if (res_q.match) idx_d = res_q.match_idx;
          else if (res_q.free) idx_d = res_q.free_idx;
          else idx_d = res_q.best_idx;
        end
      end
      default: begin
      end
    endcase
  end

  assign idx_wide = {{RES_IDX_W{1'b0}}, idx_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      found_ttl_q   <= FOUND_TTL_RST;
      missing_ttl_q <= MISSING_TTL_RST;
      start_q       <= 1'b0;
      wr_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FOUND_TTL:   found_ttl_q   <= cfg_data_i;
          REG_MISSING_TTL: missing_ttl_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      start_q <= in_acc;
      wr_q.en <= finish && wr_d;
      if (finish) begin
        wr_q.idx   <= idx_d;
        wr_q.key   <= key_q;
        wr_q.route <= (op_q == OP_FOUND) ? route_q : '0;
        wr_q.exp   <= exp_q;
      end
      if (finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_acc) state_q <= ST_SCAN;
        ST_SCAN: if (tail_i.valid) state_q <= ST_DONE;
        ST_DONE: if (out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= opcode_i;
      key_q   <= callsign_key_i;
      route_q <= route_in_i;
      now_q   <= now_ms_i;
      exp_q   <= exp_d;
    end
    if ((state_q == ST_SCAN) && tail_i.valid) res_q <= tail_i;
    if (finish) begin
      hit_q     <= hit_d;
      due_q     <= due_d;
      written_q <= wr_d;
      rout_q    <= rout_d;
      oidx_q    <= idx_wide[RES_IDX_W-1:0];
    end
  end

  assign wr_o            = wr_q;
  assign out_valid_o     = out_valid_q;
  assign route_hit_o     = hit_q;
  assign route_out_o     = rout_q;
  assign lookup_due_o    = due_q;
  assign entry_written_o = written_q;
  assign entry_index_o   = oidx_q;

endmodule

### rtl/ttl_keyed_route_cache.sv
// Top level: keyed route cache with expiry, built as a row of entry cells.
//
// Requests enter on the s_axis channel: opcode (query, mark found, mark
// missing), callsign key, route tag and current time. One result leaves on
// m_axis per request: hit flag, route, lookup-due flag, written flag and entry
// index. TTLs for found and missing results are set through the cfg channel,
// which is always ready; write it only while no request is in flight.
// A request is searched by a token that walks the row of ENTRIES cells, one
// cell per cycle, gathering match, first free/expired slot and earliest expiry.
// The result is registered once the token leaves the last cell; a new request
// is taken only after the previous one has finished its scan, so the time per
// request is set by the length of the cell row.
// A finished result sits in the output register; a new request can be taken
// while it waits, but its own result is held back until m_axis_tready frees
// the register. Reset empties every entry, zeroes all expiries and loads the
// default TTLs; the block is ready right after reset.
module ttl_keyed_route_cache (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tkrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tkrc_pkg::TTL_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // opcode[1:0], callsign_key[65:2], route_in[129:66], now_ms[177:130], zero pad
  input  logic [tkrc_pkg::IN_W-1:0]           s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // route_hit[0], route_out[64:1], lookup_due[65], entry_written[66],
  // entry_index[71:67]
  output logic [tkrc_pkg::OUT_W-1:0]          m_axis_tdata
);
  import tkrc_pkg::*;

  probe_t             probe;
  wr_t                wr;
  scan_t              chain [ENTRIES+1];
  logic               route_hit, lookup_due, entry_written;
  logic [ROUTE_W-1:0] route_out;
  logic [RES_IDX_W-1:0] entry_index;

  tkrc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .opcode_i        (s_axis_tdata[1:0]),
    .callsign_key_i  (s_axis_tdata[65:2]),
    .route_in_i      (s_axis_tdata[129:66]),
    .now_ms_i        (s_axis_tdata[177:130]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .route_hit_o     (route_hit),
    .route_out_o     (route_out),
    .lookup_due_o    (lookup_due),
    .entry_written_o (entry_written),
    .entry_index_o   (entry_index),
    .probe_o         (probe),
    .head_o          (chain[0]),
    .tail_i          (chain[ENTRIES]),
    .wr_o            (wr)
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tkrc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .probe_i    (probe),
      .wr_i       (wr),
      .scan_i     (chain[g]),
      .scan_o     (chain[g+1])
    );
  end

  assign m_axis_tdata = {entry_index, entry_written, lookup_due, route_out, route_hit};

endmodule
